/* src/sampling_insensitive_pixel_cost_core_defines.svh */
// assertion macros used by the checker file
// no dependencies
`ifndef SAMPLING_INSENSITIVE_PIXEL_COST_CORE_DEFINES_SVH
`define SAMPLING_INSENSITIVE_PIXEL_COST_CORE_DEFINES_SVH

// concurrent check, off while reset is asserted
`define SIPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that holds through reset as well
`define SIPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/sipc_pkg.sv */
// shared constants and types for the pixel cost core
// no dependencies
package sipc_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int HALF_W    = 9;

  localparam logic [10:0] WIDTH_RESET   = 11'd1024;
  localparam logic [7:0]  LABELS_RESET  = 8'd64;
  localparam logic [5:0]  COST_CAP_HALF = 6'd40;

  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_LABEL_COUNT = 1'b1;

  typedef struct packed {
    logic has_before;
    logic has_after;
  } nbr_flags_t;

endpackage

/* src/sipc_interval.sv */
// two-stage distance from a value to a half-sample interval
// depends on sipc_pkg
module sipc_interval
  import sipc_pkg::*;
(
  input  logic              clk,
  input  logic [HALF_W-1:0] v,
  input  logic [7:0]        center,
  input  logic [7:0]        prev,
  input  logic [7:0]        after,
  input  nbr_flags_t        flags,
  output logic [HALF_W-1:0] gap
);

  logic [HALF_W-1:0] c2, hb, ha;
  logic [HALF_W-1:0] lo_nxt, hi_nxt, lo_b, hi_b;
  logic [HALF_W-1:0] lo_r, hi_r, v_r, dist_r, dist_nxt;

  always_comb begin
    c2 = {center, 1'b0};
    hb = {1'b0, center} + {1'b0, prev};
    ha = {1'b0, center} + {1'b0, after};
    lo_b = c2;
    hi_b = c2;
    if (flags.has_before) begin
      if (hb < lo_b) lo_b = hb;
      if (hb > hi_b) hi_b = hb;
    end
    lo_nxt = lo_b;
    hi_nxt = hi_b;
    if (flags.has_after) begin
      if (ha < lo_b) lo_nxt = ha;
      if (ha > hi_b) hi_nxt = ha;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    v_r  <= v;
  end

  always_comb begin
    if (v_r < lo_r) begin
      dist_nxt = lo_r - v_r;
    end else if (v_r > hi_r) begin
      dist_nxt = v_r - hi_r;
    end else begin
      dist_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
  end

  assign gap = dist_r;

endmodule

/* src/sampling_insensitive_pixel_cost_core.sv */
// top level of the stereo pixel cost core with its register port
// depends on sipc_pkg and sipc_interval
//
// One pixel/disparity pair is taken in every clock cycle and its cost comes out
// at the end of the pipeline, marked by out_strobe for one cycle. The pipeline has four
// register stages: edge and range checks, interval bounds, interval distances,
// then the minimum and cap. busy stays low, so start may be held high without
// gaps. The result side cannot stall: every result must be taken in the cycle
// it is shown. Write image_width and label_count only while no pixel is in
// flight.
module sampling_insensitive_pixel_cost_core
  import sipc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  in_column,
  input  logic [7:0]  in_disparity,
  input  logic [7:0]  in_left_center,
  input  logic [7:0]  in_left_before,
  input  logic [7:0]  in_left_after,
  input  logic [7:0]  in_right_center,
  input  logic [7:0]  in_right_before,
  input  logic [7:0]  in_right_after,
  output logic        out_strobe,
  output logic [5:0]  out_cost_half,
  output logic        out_invalid,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [10:0] image_width_r;
  logic [7:0]  label_count_r;
  logic        cfg_wr;
  logic [10:0] width_eff;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= WIDTH_RESET;
      label_count_r <= LABELS_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_IMAGE_WIDTH: image_width_r <= pwdata[10:0];
        REG_LABEL_COUNT: label_count_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IMAGE_WIDTH: prdata = {21'd0, image_width_r};
      REG_LABEL_COUNT: prdata = {24'd0, label_count_r};
      default:         prdata = '0;
    endcase
  end

  assign width_eff = (image_width_r > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : image_width_r;

  function automatic nbr_flags_t nbr_flags(input logic [9:0] pos, input logic [10:0] width);
    nbr_flags_t f;
    if (pos == 10'd0) begin
      f.has_before = 1'b0;
      f.has_after  = 1'b1;
    end else begin
      f.has_before = 1'b1;
      f.has_after  = ({1'b0, pos} + 11'd1) < width;
    end
    return f;
  endfunction

  // stage 1: range check and edge flags
  logic       accept;
  logic       invalid_nxt;
  logic [9:0] q_nxt;
  logic       s1_valid_r, s1_invalid_r;
  nbr_flags_t s1_lflags_r, s1_rflags_r;
  logic [7:0] s1_lc_r, s1_lb_r, s1_la_r, s1_rc_r, s1_rb_r, s1_ra_r;

  assign accept      = start && !busy;
  assign invalid_nxt = (in_disparity >= label_count_r) || ({2'b0, in_disparity} > in_column);
  assign q_nxt       = in_column - {2'b0, in_disparity};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_invalid_r <= invalid_nxt;
    s1_lflags_r  <= nbr_flags(in_column, width_eff);
    s1_rflags_r  <= nbr_flags(q_nxt, width_eff);
    s1_lc_r      <= in_left_center;
    s1_lb_r      <= in_left_before;
    s1_la_r      <= in_left_after;
    s1_rc_r      <= in_right_center;
    s1_rb_r      <= in_right_before;
    s1_ra_r      <= in_right_after;
  end

  // stages 2 and 3: forward and reverse interval distances
  logic [HALF_W-1:0] fwd, rev;

  sipc_interval u_fwd (
    .clk    (clk),
    .v      ({s1_lc_r, 1'b0}),
    .center (s1_rc_r),
    .prev   (s1_rb_r),
    .after  (s1_ra_r),
    .flags  (s1_rflags_r),
    .gap    (fwd)
  );

  sipc_interval u_rev (
    .clk    (clk),
    .v      ({s1_rc_r, 1'b0}),
    .center (s1_lc_r),
    .prev   (s1_lb_r),
    .after  (s1_la_r),
    .flags  (s1_lflags_r),
    .gap    (rev)
  );

  logic s2_valid_r, s3_valid_r, s2_invalid_r, s3_invalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_invalid_r <= s1_invalid_r;
    s3_invalid_r <= s2_invalid_r;
  end

  // stage 4: minimum and cap
  logic [HALF_W-1:0] min_d;
  logic [5:0]        cost_nxt;
  logic              strobe_r, invalid_r;
  logic [5:0]        cost_r;

  always_comb begin
    min_d = (fwd < rev) ? fwd : rev;
    if (s3_invalid_r || (min_d > HALF_W'(COST_CAP_HALF))) begin
      cost_nxt = COST_CAP_HALF;
    end else begin
      cost_nxt = min_d[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    cost_r    <= cost_nxt;
    invalid_r <= s3_invalid_r;
  end

  assign out_strobe    = strobe_r;
  assign out_cost_half = cost_r;
  assign out_invalid   = invalid_r;

endmodule

/* src/sipc_checker.sv */
// port-level checks for the pixel cost core, bound to the top level
// depends on sampling_insensitive_pixel_cost_core_defines.svh
`include "sampling_insensitive_pixel_cost_core_defines.svh"

module sipc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic [5:0] out_cost_half,
  input logic       out_invalid
);

  `SIPC_ASSERT_ALWAYS(a_busy_low, clk, busy == 1'b0, "busy raised")
  `SIPC_ASSERT(a_latency, clk, rst_n, start |-> ##4 out_strobe, "transaction result missing")
  `SIPC_ASSERT(a_no_extra, clk, rst_n, !start |-> ##4 !out_strobe, "result without transaction")
  `SIPC_ASSERT(a_invalid_cap, clk, rst_n, (out_strobe && out_invalid) |-> (out_cost_half == 6'd40), "invalid cost not capped")
  `SIPC_ASSERT(a_cost_cap, clk, rst_n, out_strobe |-> (out_cost_half <= 6'd40), "cost above cap")

endmodule

bind sampling_insensitive_pixel_cost_core sipc_checker u_sipc_checker (.*);

/* tb/tb_sampling_insensitive_pixel_cost_core.sv */
// self-checking testbench for the stereo pixel cost core
// depends on sipc_pkg and sampling_insensitive_pixel_cost_core
// a scoreboard class predicts each cost; tasks drive pixels and the register port
module tb_sampling_insensitive_pixel_cost_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sipc_pkg::*;

  localparam logic [2:0] ADDR_IMAGE_WIDTH = {REG_IMAGE_WIDTH, 2'b00};
  localparam logic [2:0] ADDR_LABEL_COUNT = {REG_LABEL_COUNT, 2'b00};
  localparam int         PIPE_DEPTH       = 4;
  localparam int         NUM_PHASES       = 7;

  typedef struct packed {
    logic [9:0] column;
    logic [7:0] disparity;
    logic [7:0] left_center;
    logic [7:0] left_before;
    logic [7:0] left_after;
    logic [7:0] right_center;
    logic [7:0] right_before;
    logic [7:0] right_after;
  } pixel_t;

  typedef struct packed {
    logic [5:0] cost_half;
    logic       invalid;
  } cost_t;

  class pixel_cost_scoreboard;
    cost_t       expected_costs[$];
    int unsigned image_width;
    int unsigned label_count;
    int unsigned mismatches;
    int unsigned transactions;
    int unsigned invalids;
    int unsigned zeros;
    int unsigned capped;

    function new();
      image_width = WIDTH_RESET;
      label_count = LABELS_RESET;
    endfunction

    function void set_register(logic index, int unsigned value);
      if (index == REG_IMAGE_WIDTH) begin
        image_width = value & 32'h7ff;
      end else begin
        label_count = value & 32'hff;
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%t mismatch: %s", $realtime, msg);
      end
    endfunction

    function nbr_flags_t edge_nbrs(int unsigned pos, int unsigned width);
      nbr_flags_t f;
      f.has_before = (pos != 0);
      f.has_after  = (pos == 0) || (pos + 1 < width);
      return f;
    endfunction

    // distance from v to the span of the center and its present half-samples
    function int unsigned interval_gap(int unsigned v, int unsigned ctr, int unsigned bef,
                                       int unsigned aft, nbr_flags_t f);
      int unsigned lo;
      int unsigned hi;
      lo = 2 * ctr;
      hi = 2 * ctr;
      if (f.has_before) begin
        if (ctr + bef < lo) lo = ctr + bef;
        if (ctr + bef > hi) hi = ctr + bef;
      end
      if (f.has_after) begin
        if (ctr + aft < lo) lo = ctr + aft;
        if (ctr + aft > hi) hi = ctr + aft;
      end
      if (v < lo) return lo - v;
      if (v > hi) return v - hi;
      return 0;
    endfunction

    function cost_t predict_cost(pixel_t p);
      cost_t       c;
      int unsigned width;
      int unsigned match_col;
      int unsigned fwd;
      int unsigned rev;
      int unsigned best;
      width = (image_width > MAX_WIDTH) ? MAX_WIDTH : image_width;
      if (p.disparity >= label_count || p.disparity > p.column) begin
        c.cost_half = COST_CAP_HALF;
        c.invalid   = 1'b1;
        return c;
      end
      match_col = p.column - p.disparity;
      fwd = interval_gap(2 * p.left_center, p.right_center, p.right_before, p.right_after,
                         edge_nbrs(match_col, width));
      rev = interval_gap(2 * p.right_center, p.left_center, p.left_before, p.left_after,
                         edge_nbrs(p.column, width));
      best = (fwd < rev) ? fwd : rev;
      if (best > COST_CAP_HALF) best = COST_CAP_HALF;
      c.cost_half = 6'(best);
      c.invalid   = 1'b0;
      return c;
    endfunction

    function void note_pixel(pixel_t p);
      cost_t c;
      c = predict_cost(p);
      transactions++;
      if (c.invalid) invalids++;
      else if (c.cost_half == 0) zeros++;
      else if (c.cost_half == COST_CAP_HALF) capped++;
      expected_costs.push_back(c);
    endfunction

    function void check_cost(logic [5:0] cost_half, logic invalid);
      cost_t exp_c;
      if (expected_costs.size() == 0) begin
        flag($sformatf("result with nothing pending: cost_half %0d invalid %0b",
                       cost_half, invalid));
        return;
      end
      exp_c = expected_costs.pop_front();
      if (cost_half !== exp_c.cost_half) begin
        flag($sformatf("cost_half expected %0d actual %0d", exp_c.cost_half, cost_half));
      end
      if (invalid !== exp_c.invalid) begin
        flag($sformatf("invalid expected %0b actual %0b", exp_c.invalid, invalid));
      end
    endfunction

    function int unsigned pending();
      return expected_costs.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [9:0]  in_column;
  logic [7:0]  in_disparity;
  logic [7:0]  in_left_center;
  logic [7:0]  in_left_before;
  logic [7:0]  in_left_after;
  logic [7:0]  in_right_center;
  logic [7:0]  in_right_before;
  logic [7:0]  in_right_after;
  logic        out_strobe;
  logic [5:0]  out_cost_half;
  logic        out_invalid;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pixel_cost_scoreboard sb = new();
  int unsigned burst_left;
  int unsigned config_writes;
  bit          no_gaps;

  sampling_insensitive_pixel_cost_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_column      (in_column),
    .in_disparity   (in_disparity),
    .in_left_center (in_left_center),
    .in_left_before (in_left_before),
    .in_left_after  (in_left_after),
    .in_right_center(in_right_center),
    .in_right_before(in_right_before),
    .in_right_after (in_right_after),
    .out_strobe     (out_strobe),
    .out_cost_half  (out_cost_half),
    .out_invalid    (out_invalid),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        sb.note_pixel({in_column, in_disparity, in_left_center, in_left_before, in_left_after,
                       in_right_center, in_right_before, in_right_after});
      end
      if (out_strobe) begin
        sb.check_cost(out_cost_half, out_invalid);
      end
    end
  end

  initial begin
    #2ms;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("sampling_insensitive_pixel_cost_core regression: fail");
    $finish;
  end

  task automatic send_pixel(input pixel_t p);
    int unsigned gap;
    {in_column, in_disparity, in_left_center, in_left_before, in_left_after,
     in_right_center, in_right_before, in_right_after} <= p;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_pipe();
    start <= 1'b0;
    for (int k = 0; k < 1000 && sb.pending() != 0; k++) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(addr[2], data);
    config_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_check(input logic [2:0] addr, input logic [31:0] mask,
                           input logic [31:0] exp_val);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((rd & mask) !== (exp_val & mask)) begin
      sb.flag($sformatf("register at %0d expected %0d actual %0d", addr, exp_val & mask,
                        rd & mask));
    end
    @(posedge clk);
  endtask

  function automatic logic [7:0] near_value(logic [7:0] base);
    int v;
    v = int'(base) + $urandom_range(0, 8) - 4;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic pixel_t make_pixel(int unsigned width_cfg, int unsigned labels_cfg);
    pixel_t      p;
    int unsigned w;
    int unsigned max_d;
    int          col;
    w = (width_cfg > MAX_WIDTH) ? MAX_WIDTH : width_cfg;
    case ($urandom_range(0, 9))
      0: col = 0;
      1: col = 1;
      2: col = int'(w) - 2;
      3: col = int'(w) - 1;
      4: col = w;
      5: col = 1023;
      default: col = $urandom_range(0, 1023);
    endcase
    if (col < 0) col = 0;
    if (col > 1023) col = 1023;
    p.column = 10'(col);
    if (labels_cfg == 0 || $urandom_range(0, 3) == 0) begin
      p.disparity = 8'($urandom_range(0, 255));
    end else begin
      max_d = (col < labels_cfg - 1) ? col : labels_cfg - 1;
      if ($urandom_range(0, 4) == 0) p.disparity = 8'(max_d);
      else if ($urandom_range(0, 6) == 0 && col + 1 >= w && col - int'(w) + 1 <= max_d)
        p.disparity = 8'((col + 1 > w) ? col + 1 - w : 0);
      else p.disparity = 8'($urandom_range(0, max_d));
    end
    p.left_center = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 2) == 0) begin
      p.right_center = 8'($urandom_range(0, 255));
      p.left_before  = 8'($urandom_range(0, 255));
      p.left_after   = 8'($urandom_range(0, 255));
      p.right_before = 8'($urandom_range(0, 255));
      p.right_after  = 8'($urandom_range(0, 255));
    end else begin
      // nearby intensities so costs land between zero and the cap
      p.right_center = near_value(near_value(p.left_center));
      p.left_before  = near_value(p.left_center);
      p.left_after   = near_value(p.left_center);
      p.right_before = near_value(p.right_center);
      p.right_after  = near_value(p.right_center);
    end
    return p;
  endfunction

  function automatic pixel_t pix(int col, int disp, int lc, int lb, int la,
                                 int rc, int rb, int ra);
    pixel_t p;
    p = {10'(col), 8'(disp), 8'(lc), 8'(lb), 8'(la), 8'(rc), 8'(rb), 8'(ra)};
    return p;
  endfunction

  int unsigned width_plan[NUM_PHASES]  = '{1024, 2, 8, 2047, 0, 37, 1025};
  int unsigned labels_plan[NUM_PHASES] = '{64, 1, 255, 200, 0, 16, 255};
  int unsigned items_plan[NUM_PHASES]  = '{110, 80, 110, 110, 20, 100, 100};

  initial begin
    pixel_t directed[$];
    rst_n      <= 1'b0;
    start      <= 1'b0;
    {in_column, in_disparity, in_left_center, in_left_before, in_left_after,
     in_right_center, in_right_before, in_right_after} <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    burst_left = 8;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    reg_check(ADDR_IMAGE_WIDTH, 32'h7ff, WIDTH_RESET);
    reg_check(ADDR_LABEL_COUNT, 32'hff, LABELS_RESET);

    // edges, range checks, zero and capped costs under reset settings
    directed.push_back(pix(0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(pix(0, 0, 255, 0, 0, 0, 0, 0));
    directed.push_back(pix(0, 0, 255, 255, 255, 255, 255, 255));
    directed.push_back(pix(1023, 0, 255, 255, 255, 255, 255, 255));
    directed.push_back(pix(1023, 63, 100, 90, 140, 110, 100, 130));
    directed.push_back(pix(1022, 0, 100, 100, 120, 110, 110, 90));
    directed.push_back(pix(10, 10, 50, 60, 40, 52, 200, 48));
    directed.push_back(pix(5, 6, 1, 2, 3, 4, 5, 6));
    directed.push_back(pix(300, 64, 1, 2, 3, 4, 5, 6));
    directed.push_back(pix(300, 255, 1, 2, 3, 4, 5, 6));
    directed.push_back(pix(200, 3, 100, 100, 100, 102, 96, 110));
    directed.push_back(pix(200, 3, 100, 100, 100, 110, 110, 110));
    directed.push_back(pix(200, 3, 100, 100, 120, 108, 108, 108));
    directed.push_back(pix(512, 32, 255, 0, 255, 0, 255, 0));
    directed.push_back(pix(1, 1, 170, 85, 170, 85, 170, 85));
    directed.push_back(pix(1, 0, 85, 170, 85, 170, 85, 170));
    directed.push_back(pix(700, 63, 0, 255, 0, 255, 0, 255));
    foreach (directed[k]) send_pixel(directed[k]);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        drain_pipe();
        reg_write(ADDR_IMAGE_WIDTH, width_plan[ph]);
        reg_write(ADDR_LABEL_COUNT, labels_plan[ph]);
        reg_check(ADDR_IMAGE_WIDTH, 32'h7ff, width_plan[ph]);
        reg_check(ADDR_LABEL_COUNT, 32'hff, labels_plan[ph]);
      end
      no_gaps = (ph == 2);
      for (int n = 0; n < items_plan[ph]; n++) begin
        send_pixel(make_pixel(width_plan[ph], labels_plan[ph]));
      end
    end

    drain_pipe();
    if (sb.pending() != 0) begin
      sb.flag($sformatf("%0d results never arrived", sb.pending()));
    end
    $display("covered %0d pixels over %0d register writes: %0d invalid, %0d zero, %0d capped",
             sb.transactions, config_writes, sb.invalids, sb.zeros, sb.capped);
    $display("mismatches counted: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("sampling_insensitive_pixel_cost_core regression: pass");
    end else begin
      $display("sampling_insensitive_pixel_cost_core regression: fail");
    end
    $finish;
  end
endmodule
